### hw/rtl/ple_pkg.sv
`timescale 1ns / 1ps
// shared codes and types for the positional list engine
// no dependencies; imported by ple_ctrl, ple_dp and positional_list_engine_top
package ple_pkg;

    // command codes on s_cmd
    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_REMOVE  = 3'd1;
    localparam logic [2:0] CMD_READ    = 3'd2;
    localparam logic [2:0] CMD_REPLACE = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    // status codes on m_status
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_CAPTURE    = 4'd1;
    localparam logic [3:0] OP_REJECT     = 4'd2;
    localparam logic [3:0] OP_INS_START  = 4'd3;
    localparam logic [3:0] OP_INS_STEP   = 4'd4;
    localparam logic [3:0] OP_INS_FINAL  = 4'd5;
    localparam logic [3:0] OP_REM_START  = 4'd6;
    localparam logic [3:0] OP_REM_STEP   = 4'd7;
    localparam logic [3:0] OP_REM_LAST   = 4'd8;
    localparam logic [3:0] OP_READ_START = 4'd9;
    localparam logic [3:0] OP_READ_DONE  = 4'd10;
    localparam logic [3:0] OP_REPLACE    = 4'd11;
    localparam logic [3:0] OP_CLEAR      = 4'd12;
    localparam logic [3:0] OP_LOAD_OUT   = 4'd13;

    typedef struct packed {
        logic [3:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;        // latched command
        logic       pos_bad;    // position out of range for that command
        logic       full;       // list holds DEPTH entries
        logic       ins_direct; // insert at the tail, nothing to move
        logic       rem_last;   // remove of the tail entry, nothing to move
        logic       step_last;  // current move is the final one
        logic       slot_free;  // output register can take a word now
    } dp_stat_t;

endpackage

### hw/rtl/ple_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ple_ctrl.sv
`timescale 1ns / 1ps
// controller state machine for the positional list engine
// depends on ple_pkg; drives ple_dp through dp_cmd_t and reads dp_stat_t
module ple_ctrl
    import ple_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output dp_cmd_t  dp_cmd,
    input  dp_stat_t dp_stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_INS   = 3'd2;
    localparam logic [2:0] S_INSV  = 3'd3;
    localparam logic [2:0] S_REM   = 3'd4;
    localparam logic [2:0] S_RDW   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        dp_cmd.op  = OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dp_cmd.op  = OP_CAPTURE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = S_DONE;
                case (dp_stat.cmd)
                    CMD_INSERT: begin
                        if (dp_stat.pos_bad || dp_stat.full) begin
                            dp_cmd.op = OP_REJECT;
                        end else if (dp_stat.ins_direct) begin
                            dp_cmd.op = OP_INS_FINAL;
                        end else begin
                            dp_cmd.op  = OP_INS_START;
                            state_next = S_INS;
                        end
                    end
                    CMD_REMOVE: begin
                        if (dp_stat.pos_bad) begin
                            dp_cmd.op = OP_REJECT;
                        end else if (dp_stat.rem_last) begin
                            dp_cmd.op = OP_REM_LAST;
                        end else begin
                            dp_cmd.op  = OP_REM_START;
                            state_next = S_REM;
                        end
                    end
                    CMD_READ: begin
                        if (dp_stat.pos_bad) begin
                            dp_cmd.op = OP_REJECT;
                        end else begin
                            dp_cmd.op  = OP_READ_START;
                            state_next = S_RDW;
                        end
                    end
                    CMD_REPLACE: begin
                        dp_cmd.op = dp_stat.pos_bad ? OP_REJECT : OP_REPLACE;
                    end
                    CMD_CLEAR: begin
                        dp_cmd.op = OP_CLEAR;
                    end
                    default: begin
                        dp_cmd.op = OP_NONE;
                    end
                endcase
            end
            S_INS: begin
                dp_cmd.op = OP_INS_STEP;
                if (dp_stat.step_last) begin
                    state_next = S_INSV;
                end
            end
            S_INSV: begin
                dp_cmd.op  = OP_INS_FINAL;
                state_next = S_DONE;
            end
            S_REM: begin
                dp_cmd.op = OP_REM_STEP;
                if (dp_stat.step_last) begin
                    state_next = S_DONE;
                end
            end
            S_RDW: begin
                dp_cmd.op  = OP_READ_DONE;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (dp_stat.slot_free) begin
                    dp_cmd.op  = OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && dp_stat.slot_free) |=> state_reg == S_IDLE)
        else $error("controller did not return to idle after loading a result");
`endif

endmodule

### hw/rtl/ple_dp.sv
`timescale 1ns / 1ps
// datapath for the positional list engine: count, move pointer, entry ram, result regs
// depends on ple_pkg and ple_ram; controlled by ple_ctrl
module ple_dp
    import ple_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [2:0]  s_cmd,
    input  logic [7:0]  s_position,
    input  logic [31:0] s_value,
    input  dp_cmd_t     dp_cmd,
    output dp_stat_t    dp_stat,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [31:0] m_read_value,
    output logic [1:0]  m_status,
    output logic [6:0]  m_count,
    output logic        m_empty_res
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = ((CNT_W > 8) ? CNT_W : 8) + 1;
    localparam int MAXW  = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [7:0]             pos_reg, pos_next;
    logic [31:0]            val_reg, val_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [31:0]            res_rd_reg, res_rd_next;
    logic [31:0]            out_rd_reg, out_rd_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic [6:0]             out_count_reg, out_count_next;
    logic                   out_empty_reg, out_empty_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

    logic [CW-1:0]          cnt_ext, pos_ext, ptr_ext;
    logic [CW-1:0]          cnt_m1, cnt_p1, pos_m1, ptr_m1, ptr_m2, ptr_p1, ptr_p2;
    logic [MAXW-1:0]        val_ext, rd_ext;
    logic [VALUE_WIDTH-1:0] val_w;

    assign cnt_ext = CW'(count_reg);
    assign pos_ext = CW'(pos_reg);
    assign ptr_ext = CW'(ptr_reg);
    assign cnt_m1  = cnt_ext - CW'(1);
    assign cnt_p1  = cnt_ext + CW'(1);
    assign pos_m1  = pos_ext - CW'(1);
    assign ptr_m1  = ptr_ext - CW'(1);
    assign ptr_m2  = ptr_ext - CW'(2);
    assign ptr_p1  = ptr_ext + CW'(1);
    assign ptr_p2  = ptr_ext + CW'(2);
    assign val_ext = MAXW'(val_reg);
    assign val_w   = val_ext[VALUE_WIDTH-1:0];
    assign rd_ext  = MAXW'(ram_rdata);

    // status toward the controller
    always_comb begin
        dp_stat.cmd        = cmd_reg;
        dp_stat.full       = (cnt_ext == CW'(DEPTH));
        dp_stat.ins_direct = (pos_ext == cnt_p1);
        dp_stat.rem_last   = (pos_ext == cnt_ext);
        dp_stat.slot_free  = !m_valid_reg || m_ready;
        if (cmd_reg == CMD_INSERT) begin
            dp_stat.pos_bad   = (pos_ext == '0) || (pos_ext > cnt_p1);
            dp_stat.step_last = (ptr_ext == pos_ext);
        end else begin
            dp_stat.pos_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);
            dp_stat.step_last = (ptr_p2 == cnt_ext);
        end
    end

    always_comb begin
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        out_rd_next     = out_rd_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = ptr_reg;
        case (dp_cmd.op)
            OP_CAPTURE: begin
                cmd_next        = s_cmd;
                pos_next        = s_position;
                val_next        = s_value;
                res_status_next = ST_OK;
                res_rd_next     = '0;
            end
            OP_REJECT: begin
                res_status_next = dp_stat.pos_bad ? ST_BADPOS : ST_FULL;
            end
            OP_INS_START: begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1[AW-1:0];
                ptr_next  = cnt_ext[AW-1:0];
            end
            OP_INS_STEP: begin
                ram_we = 1'b1;
                if (!dp_stat.step_last) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_m2[AW-1:0];
                    ptr_next  = ptr_m1[AW-1:0];
                end
            end
            OP_INS_FINAL: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_m1[AW-1:0];
                ram_wdata  = val_w;
                count_next = cnt_p1[CNT_W-1:0];
            end
            OP_REM_START: begin
                ram_re    = 1'b1;
                ram_raddr = pos_ext[AW-1:0];
                ptr_next  = pos_m1[AW-1:0];
            end
            OP_REM_STEP: begin
                ram_we = 1'b1;
                if (dp_stat.step_last) begin
                    count_next = cnt_m1[CNT_W-1:0];
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_p2[AW-1:0];
                    ptr_next  = ptr_p1[AW-1:0];
                end
            end
            OP_REM_LAST: begin
                count_next = cnt_m1[CNT_W-1:0];
            end
            OP_READ_START: begin
                ram_re    = 1'b1;
                ram_raddr = pos_m1[AW-1:0];
            end
            OP_READ_DONE: begin
                res_rd_next = rd_ext[31:0];
            end
            OP_REPLACE: begin
                ram_we    = 1'b1;
                ram_waddr = pos_m1[AW-1:0];
                ram_wdata = val_w;
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            OP_LOAD_OUT: begin
                m_valid_next    = 1'b1;
                out_rd_next     = res_rd_reg;
                out_status_next = res_status_reg;
                out_count_next  = cnt_ext[6:0];
                out_empty_next  = (count_reg == '0);
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        out_rd_reg     <= out_rd_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

    ple_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid      = m_valid_reg;
    assign m_read_value = out_rd_reg;
    assign m_status     = out_status_reg;
    assign m_count      = out_count_reg;
    assign m_empty_res  = out_empty_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_ext <= CW'(DEPTH))
        else $error("entry count above depth");
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("ram read and write hit the same entry");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op == OP_LOAD_OUT) |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a word not yet taken");
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op == OP_INS_FINAL) |=> (CW'(count_reg) == $past(cnt_p1)))
        else $error("insert did not grow the list by one");
`endif

endmodule

### hw/rtl/positional_list_engine_top.sv
`timescale 1ns / 1ps
// top level of the positional list engine
// depends on ple_pkg, ple_ctrl, ple_dp (which holds ple_ram)

// ordered list of up to DEPTH entries, addressed by 1-based position. one input
// word carries a command (insert before, remove, read, replace, clear) and gives
// exactly one result word: read value (zero unless a good read), status (ok, bad
// position, full), entry count after the command and an empty flag. entries live
// in a single ram with one write and one registered read port, so insert and
// remove move one entry per cycle. one command is in work at a time; a finished
// result waits in the output register, so the next word is taken while the
// previous result is still unread. entry storage has no reset and is never read
// outside positions 1..count.
module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [7:0]  s_position,
    input  logic [31:0] s_value,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_value,
    output logic [1:0]  m_status,
    output logic [6:0]  m_count,
    output logic        m_empty_res
);

    // operation strobes one way, range and progress flags the other
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer: decode, move loop, result handoff
    ple_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

    // count, move pointer, entry ram and output register
    ple_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_cmd        (s_cmd),
        .s_position   (s_position),
        .s_value      (s_value),
        .dp_cmd       (dp_cmd),
        .dp_stat      (dp_stat),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_empty_res  (m_empty_res)
    );

endmodule
